// ===== rtl/kptl_pkg.sv =====
// ----------------------------------------------------------------------------
// kptl_pkg: shared types and constants of the keyed position table
// Entry layout, request and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package kptl_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int KEY_W       = 64;
	localparam int VAL_W       = 32;
	localparam int AGE_W       = 32;
	localparam int CNT_OUT_W   = 6;

	typedef enum logic [1:0] {
		CMD_GET   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_GET_MISS   = 3'd0,
		ST_GET_HIT    = 3'd1,
		ST_UPDATED    = 3'd2,
		ST_INSERTED   = 3'd3,
		ST_EVICTED    = 3'd4,
		ST_REMOVED    = 3'd5,
		ST_CLEAR_MISS = 3'd6,
		ST_DISABLED   = 3'd7
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] pos;
		logic [VAL_W-1:0] dur;
		logic [AGE_W-1:0] age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_ACT,
		S_ARD,
		S_ACMP,
		S_EVW,
		S_SRD,
		S_SWR
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/keyed_position_table_lru.sv =====
// ----------------------------------------------------------------------------
// keyed_position_table_lru: associative table of resume positions
// Get, set and clear requests on 64-bit keys, replacing the least recently set entry.
// ----------------------------------------------------------------------------
// A request (cmd, key, position_ms, duration_ms) is taken at a clock edge
// where start is high and busy is low. Its single result appears on status,
// out_position_ms, out_duration_ms and entry_count for exactly one cycle,
// marked by done; the receiver takes it at the end of that cycle and cannot
// hold it off. busy is low again in the cycle that shows done, so the next
// request may be taken while the result is on the ports.
// All entries sit in one RAM with a registered read, so every entry visit
// takes a read state and then a check state. A get or a set scans the live
// entries. A set of a new key into a full table adds a stamp scan over all
// ENTRIES entries; a clear that hits moves each later entry down by one.
// The worst case is a set of a new key into a full table. The enable
// register is written over its own channel, which is always ready; the
// user must write it only while no request is in flight, as the block
// itself does not enforce this.
// Reset empties the table, clears the set counter and enables the table;
// no clearing pass is needed, since entries beyond the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_position_table_lru #(
	parameter int ENTRIES = kptl_pkg::ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       cmd,
	input  wire logic [kptl_pkg::KEY_W-1:0]       key,
	input  wire logic [kptl_pkg::VAL_W-1:0]       position_ms,
	input  wire logic [kptl_pkg::VAL_W-1:0]       duration_ms,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_data,
	output logic                                  done,
	output logic [2:0]                            status,
	output logic [kptl_pkg::VAL_W-1:0]            out_position_ms,
	output logic [kptl_pkg::VAL_W-1:0]            out_duration_ms,
	output logic [kptl_pkg::CNT_OUT_W-1:0]        entry_count
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	kptl_pkg::state_t state_q, state_nxt;

	logic                         enable_q;
	logic [CW-1:0]                count_q, cnt_nxt;
	logic [kptl_pkg::AGE_W-1:0]   seq_q;
	logic [CW-1:0]                ptr_q, ptr_plus;
	logic [IW-1:0]                idx_q, victim_q;
	logic [kptl_pkg::AGE_W-1:0]   best_q;
	logic                         hit_q;
	logic                         done_q;
	kptl_pkg::status_t            status_q;
	logic [kptl_pkg::VAL_W-1:0]   opos_q, odur_q;
	logic [kptl_pkg::CNT_OUT_W-1:0] ecount_q;

	kptl_pkg::cmd_t               cmd_q;
	logic [kptl_pkg::KEY_W-1:0]   key_q;
	logic [kptl_pkg::VAL_W-1:0]   pos_q, dur_q;

	logic                         ram_wr_en, ram_rd_en;
	logic [IW-1:0]                ram_wr_addr, ram_rd_addr;
	kptl_pkg::entry_t             ram_wr_data, rd_entry;
	logic [kptl_pkg::ENTRY_W-1:0] ram_rd_data;

	logic                         fin;
	kptl_pkg::status_t            fin_status;
	logic [kptl_pkg::VAL_W-1:0]   fin_pos, fin_dur;
	logic                         key_match, full;

	assign rd_entry  = kptl_pkg::entry_t'(ram_rd_data);
	assign key_match = (rd_entry.key == key_q);
	assign full      = (count_q == CW'(ENTRIES));
	assign ptr_plus  = ptr_q + CW'(1);

	kptl_ram #(
		.WIDTH (kptl_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			kptl_pkg::S_IDLE: begin
				if (start) begin
					if (!enable_q || cmd == kptl_pkg::CMD_NONE) begin
						state_nxt = kptl_pkg::S_ACT;
					end else begin
						state_nxt = kptl_pkg::S_RD;
					end
				end
			end
			kptl_pkg::S_RD: begin
				state_nxt = (ptr_q == count_q) ? kptl_pkg::S_ACT : kptl_pkg::S_CMP;
			end
			kptl_pkg::S_CMP: begin
				state_nxt = key_match ? kptl_pkg::S_ACT : kptl_pkg::S_RD;
			end
			kptl_pkg::S_ACT: begin
				state_nxt = kptl_pkg::S_IDLE;
				if (enable_q && cmd_q == kptl_pkg::CMD_SET && !hit_q && full) begin
					state_nxt = kptl_pkg::S_ARD;
				end else if (enable_q && cmd_q == kptl_pkg::CMD_CLEAR && hit_q) begin
					state_nxt = kptl_pkg::S_SRD;
				end
			end
			kptl_pkg::S_ARD: begin
				state_nxt = kptl_pkg::S_ACMP;
			end
			kptl_pkg::S_ACMP: begin
				state_nxt = (ptr_q == CW'(ENTRIES - 1)) ? kptl_pkg::S_EVW : kptl_pkg::S_ARD;
			end
			kptl_pkg::S_EVW: begin
				state_nxt = kptl_pkg::S_IDLE;
			end
			kptl_pkg::S_SRD: begin
				state_nxt = (ptr_plus < count_q) ? kptl_pkg::S_SWR : kptl_pkg::S_IDLE;
			end
			kptl_pkg::S_SWR: begin
				state_nxt = kptl_pkg::S_SRD;
			end
			default: begin
				state_nxt = kptl_pkg::S_IDLE;
			end
		endcase
	end

	// Memory controls and result selection.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '{key: key_q, pos: pos_q, dur: dur_q, age: seq_q};
		ram_rd_en   = 1'b0;
		ram_rd_addr = ptr_q[IW-1:0];
		fin         = 1'b0;
		fin_status  = kptl_pkg::ST_GET_MISS;
		fin_pos     = '0;
		fin_dur     = '0;
		cnt_nxt     = count_q;
		case (state_q)
			kptl_pkg::S_RD: begin
				ram_rd_en = (ptr_q != count_q);
			end
			kptl_pkg::S_ACT: begin
				if (!enable_q) begin
					fin        = 1'b1;
					fin_status = kptl_pkg::ST_DISABLED;
				end else begin
					case (cmd_q)
						kptl_pkg::CMD_GET: begin
							fin = 1'b1;
							if (hit_q) begin
								fin_status = kptl_pkg::ST_GET_HIT;
								fin_pos    = rd_entry.pos;
								fin_dur    = rd_entry.dur;
							end
						end
						kptl_pkg::CMD_SET: begin
							if (hit_q) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = idx_q;
								fin         = 1'b1;
								fin_status  = kptl_pkg::ST_UPDATED;
							end else if (!full) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = count_q[IW-1:0];
								cnt_nxt     = count_q + CW'(1);
								fin         = 1'b1;
								fin_status  = kptl_pkg::ST_INSERTED;
							end
						end
						kptl_pkg::CMD_CLEAR: begin
							if (!hit_q) begin
								fin        = 1'b1;
								fin_status = kptl_pkg::ST_CLEAR_MISS;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			kptl_pkg::S_ARD: begin
				ram_rd_en = 1'b1;
			end
			kptl_pkg::S_EVW: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = victim_q;
				fin         = 1'b1;
				fin_status  = kptl_pkg::ST_EVICTED;
			end
			kptl_pkg::S_SRD: begin
				if (ptr_plus < count_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = ptr_plus[IW-1:0];
				end else begin
					cnt_nxt    = count_q - CW'(1);
					fin        = 1'b1;
					fin_status = kptl_pkg::ST_REMOVED;
				end
			end
			kptl_pkg::S_SWR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = ptr_q[IW-1:0];
				ram_wr_data = rd_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kptl_pkg::S_IDLE;
			enable_q <= 1'b1;
			count_q  <= '0;
			seq_q    <= '0;
			ptr_q    <= '0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= cnt_nxt;
			done_q  <= fin;
			if (cfg_valid) begin
				enable_q <= cfg_data;
			end
			case (state_q)
				kptl_pkg::S_IDLE: begin
					if (start) begin
						ptr_q <= '0;
						hit_q <= 1'b0;
						if (enable_q && cmd == kptl_pkg::CMD_SET) begin
							seq_q <= seq_q + kptl_pkg::AGE_W'(1);
						end
					end
				end
				kptl_pkg::S_CMP: begin
					if (key_match) begin
						hit_q <= 1'b1;
					end else begin
						ptr_q <= ptr_plus;
					end
				end
				kptl_pkg::S_ACT: begin
					// A clear shifts from the hit entry; an eviction scans from zero.
					ptr_q <= hit_q ? CW'(idx_q) : '0;
				end
				kptl_pkg::S_ACMP, kptl_pkg::S_SWR: begin
					ptr_q <= ptr_plus;
				end
				default: begin
				end
			endcase
		end
	end

	// Request payload, hit index, eviction search and result registers.
	always_ff @(posedge clk) begin
		if (state_q == kptl_pkg::S_IDLE && start) begin
			cmd_q <= kptl_pkg::cmd_t'(cmd);
			key_q <= key;
			pos_q <= position_ms;
			dur_q <= duration_ms;
		end
		if (state_q == kptl_pkg::S_CMP && key_match) begin
			idx_q <= ptr_q[IW-1:0];
		end
		// Strictly smaller stamps win, so ties keep the lowest index.
		if (state_q == kptl_pkg::S_ACMP) begin
			if (ptr_q == '0 || rd_entry.age < best_q) begin
				best_q   <= rd_entry.age;
				victim_q <= ptr_q[IW-1:0];
			end
		end
		if (fin) begin
			status_q <= fin_status;
			opos_q   <= fin_pos;
			odur_q   <= fin_dur;
			ecount_q <= kptl_pkg::CNT_OUT_W'(cnt_nxt);
		end
	end

	assign busy            = (state_q != kptl_pkg::S_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign status          = status_q;
	assign out_position_ms = opos_q;
	assign out_duration_ms = odur_q;
	assign entry_count     = ecount_q;

endmodule

`default_nettype wire

// ===== rtl/kptl_ram.sv =====
// ----------------------------------------------------------------------------
// kptl_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_ram #(
	parameter int WIDTH = kptl_pkg::ENTRY_W,
	parameter int DEPTH = kptl_pkg::ENTRIES_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/kptl_chk.sv =====
// ----------------------------------------------------------------------------
// kptl_chk: port-level checks of the keyed position table
// Request and result sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module kptl_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      done,
	input wire logic [2:0]                status,
	input wire logic [kptl_pkg::VAL_W-1:0] out_position_ms,
	input wire logic [kptl_pkg::VAL_W-1:0] out_duration_ms
);

	// A result is only shown once the request is finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in flight");

	// Every taken request makes the block busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request transfer did not make the block busy");

	// One request gives one result, never two in a row.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// Only a get hit carries stored values.
	a_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != 3'(kptl_pkg::ST_GET_HIT))
		|-> (out_position_ms == '0 && out_duration_ms == '0))
		else $error("values returned on a result other than a get hit");

endmodule

bind keyed_position_table_lru kptl_chk u_kptl_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.status          (status),
	.out_position_ms (out_position_ms),
	.out_duration_ms (out_duration_ms)
);

`default_nettype wire
